// ===== hw/rtl/atss_pkg.sv =====
// ----------------------------------------------------------------------------
// Appliance terminal state sensor package
// Shared word formats, state record, configuration record and codes.
// ----------------------------------------------------------------------------
package atss_pkg;

  localparam int ATSS_NUM_PORTS = 2;
  localparam logic [15:0] CNT_MAX = 16'hffff;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_CHANGE = 2'd2;

  localparam logic [1:0] REP_OFF = 2'd0;
  localparam logic [1:0] REP_ON  = 2'd1;
  localparam logic [1:0] REP_ERR = 2'd2;

  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_GLITCH = 2'd1;
  localparam logic [1:0] CFG_PULSE  = 2'd2;
  localparam logic [1:0] CFG_SETTLE = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_MEAS1  = 5'b00010,
    PH_PULSE  = 5'b00100,
    PH_SETTLE = 5'b01000,
    PH_MEAS2  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] port_select;
    logic       target_state;
    logic [1:0] monitor_pins;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  control_pins;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  reported_state;
    logic [15:0] edge_count;
  } out_word_t;

  typedef struct packed {
    logic [15:0] window_ticks;
    logic [15:0] glitch_ticks;
    logic [15:0] pulse_ticks;
    logic [15:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        active_port;
    logic        wanted_state;
    logic        is_change;
    logic        previous_level;
    logic [15:0] run_length;
    logic [15:0] earlier_run_length;
    logic [15:0] change_count;
    logic [15:0] tick_counter;
    logic [1:0]  control_drive;
  } state_t;

endpackage

// ===== hw/rtl/atss_step.sv =====
// ----------------------------------------------------------------------------
// Sensor tick step
// Next state and result word for one tick: request decode, edge filter,
// window, pulse and settle timing.
// ----------------------------------------------------------------------------
module atss_step (
  input  atss_pkg::state_t    state_i,
  input  atss_pkg::cfg_t      cfg_i,
  input  atss_pkg::in_word_t  word_i,
  output atss_pkg::state_t    state_o,
  output atss_pkg::out_word_t word_o
);
  import atss_pkg::*;

  state_t      nxt;
  logic        done;
  logic [1:0]  report;
  logic [15:0] edges;
  logic        lvl;
  logic        start_lvl;
  logic        win_lvl;
  logic        st_lvl;
  logic [16:0] merged;
  logic [15:0] tc_inc;

  assign lvl       = ~word_i.monitor_pins[state_i.active_port];
  assign start_lvl = ~word_i.monitor_pins[word_i.port_select[0]];
  assign merged    = {1'b0, state_i.earlier_run_length} + {1'b0, state_i.run_length};
  assign tc_inc    = state_i.tick_counter + 16'd1;

  always_comb begin
    nxt     = state_i;
    done    = 1'b0;
    report  = REP_OFF;
    edges   = '0;
    win_lvl = lvl;
    st_lvl  = 1'b0;
    unique case (state_i.phase)
      PH_IDLE: begin
        if (word_i.func == FUNC_READ || word_i.func == FUNC_CHANGE) begin
          if ({1'b0, word_i.port_select} >= 3'(ATSS_NUM_PORTS)) begin
            done   = 1'b1;
            report = REP_ERR;
          end else begin
            nxt.active_port        = word_i.port_select[0];
            nxt.wanted_state       = word_i.target_state;
            nxt.is_change          = (word_i.func == FUNC_CHANGE);
            nxt.change_count       = '0;
            nxt.previous_level     = start_lvl;
            nxt.run_length         = '0;
            nxt.earlier_run_length = '0;
            nxt.tick_counter       = '0;
            nxt.phase              = PH_MEAS1;
          end
        end
      end
      PH_MEAS1, PH_MEAS2: begin
        if (win_lvl != state_i.previous_level) begin
          if (!win_lvl && state_i.change_count != 16'd0 &&
              state_i.run_length < cfg_i.glitch_ticks) begin
            nxt.change_count       = state_i.change_count - 16'd1;
            nxt.run_length         = merged[16] ? CNT_MAX : merged[15:0];
            nxt.earlier_run_length = '0;
          end else begin
            if (state_i.change_count != CNT_MAX) begin
              nxt.change_count = state_i.change_count + 16'd1;
            end
            nxt.earlier_run_length = state_i.run_length;
            nxt.run_length         = '0;
          end
          nxt.previous_level = win_lvl;
        end else if (state_i.run_length != CNT_MAX) begin
          nxt.run_length = state_i.run_length + 16'd1;
        end
        nxt.tick_counter = tc_inc;
        if (tc_inc >= cfg_i.window_ticks) begin
          st_lvl = (nxt.change_count >= 16'd2) ? 1'b1 : win_lvl;
          if (state_i.phase == PH_MEAS1 && state_i.is_change &&
              st_lvl != state_i.wanted_state) begin
            nxt.control_drive = state_i.control_drive & ~(2'b01 << state_i.active_port);
            nxt.tick_counter  = '0;
            nxt.phase         = PH_PULSE;
          end else begin
            done      = 1'b1;
            report    = {1'b0, st_lvl};
            edges     = nxt.change_count;
            nxt.phase = PH_IDLE;
          end
        end
      end
      PH_PULSE: begin
        nxt.tick_counter = tc_inc;
        if (tc_inc >= cfg_i.pulse_ticks) begin
          nxt.control_drive = 2'b11;
          nxt.tick_counter  = '0;
          nxt.phase         = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (state_i.tick_counter >= cfg_i.settle_ticks) begin
          nxt.change_count       = '0;
          nxt.previous_level     = lvl;
          nxt.run_length         = '0;
          nxt.earlier_run_length = '0;
          nxt.tick_counter       = '0;
          nxt.phase              = PH_MEAS2;
        end else begin
          nxt.tick_counter = tc_inc;
        end
      end
      default: begin
        nxt.phase         = PH_IDLE;
        nxt.control_drive = 2'b11;
      end
    endcase
  end

  assign state_o             = nxt;
  assign word_o.control_pins   = nxt.control_drive;
  assign word_o.busy_res       = (nxt.phase != PH_IDLE);
  assign word_o.done_res       = done;
  assign word_o.reported_state = report;
  assign word_o.edge_count     = edges;

endmodule

// ===== hw/rtl/appliance_terminal_state_sensor_unit.sv =====
// ----------------------------------------------------------------------------
// Appliance terminal state sensor unit
// Reads and changes the on/off state of two terminal ports, one word per tick.
// ----------------------------------------------------------------------------
// Each input word is one 100 us tick and yields exactly one result word.
// A word passes an input register, then the combinational step logic into the
// result register, so a new word is taken every cycle; only a stalled result
// register holds the input side back.
// Configuration writes are taken at any time but are meant for idle periods.
module appliance_terminal_state_sensor_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  atss_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output atss_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import atss_pkg::*;

  in_word_t  in_word_r;
  logic      in_valid_r, in_valid_nxt;
  out_word_t out_word_r;
  logic      out_valid_r, out_valid_nxt;
  state_t    state_r, state_nxt;
  cfg_t      cfg_r;
  out_word_t step_word;
  logic      adv_out;
  logic      fire;
  logic      in_acc;

  assign adv_out  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && adv_out;
  assign in_stall = in_valid_r && !adv_out;
  assign in_acc   = in_valid && !in_stall;

  atss_step u_step (
    .state_i (state_r),
    .cfg_i   (cfg_r),
    .word_i  (in_word_r),
    .state_o (state_nxt),
    .word_o  (step_word)
  );

  always_comb begin
    in_valid_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : in_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_word_r <= in_word;
    end
    if (fire) begin
      out_word_r <= step_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase              <= PH_IDLE;
      state_r.active_port        <= 1'b0;
      state_r.wanted_state       <= 1'b0;
      state_r.is_change          <= 1'b0;
      state_r.previous_level     <= 1'b0;
      state_r.run_length         <= '0;
      state_r.earlier_run_length <= '0;
      state_r.change_count       <= '0;
      state_r.tick_counter       <= '0;
      state_r.control_drive      <= 2'b11;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks <= 16'd400;
      cfg_r.glitch_ticks <= 16'd8;
      cfg_r.pulse_ticks  <= 16'd2200;
      cfg_r.settle_ticks <= 16'd1300;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW: cfg_r.window_ticks <= cfg_data;
        CFG_GLITCH: cfg_r.glitch_ticks <= cfg_data;
        CFG_PULSE:  cfg_r.pulse_ticks  <= cfg_data;
        CFG_SETTLE: cfg_r.settle_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.done_res && out_word.busy_res))
    else $error("done and busy reported together");

  a_error_no_edges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.reported_state == REP_ERR) |->
      (out_word.edge_count == 16'd0 && out_word.done_res))
    else $error("error report carries an edge count or lacks done");

  a_pulse_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.control_drive != 2'b11) |-> (state_r.phase == PH_PULSE))
    else $error("control pin driven low outside the pulse phase");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("sensor state changed without a tick");

endmodule

// ===== bench/tb_appliance_terminal_state_sensor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Appliance terminal state sensor unit testbench
// Sends tick words that carry state reads, state changes and monitor pin
// traffic, and predicts every result word from a model of the sensor.
// Each result is checked against the predicted one. The run covers the reset
// settings, a directed set of corner cases, long windows, pulses and settle
// times, and many random configurations with gaps on both channels.
// ----------------------------------------------------------------------------
module tb_appliance_terminal_state_sensor_unit;
  import atss_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int ITEM_GOAL = 1800;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  cfg_t        sensor_cfg;
  state_t      sensor_st;
  out_word_t   pending_reports[$];
  logic [1:0]  pin_state;
  int          mismatches = 0;
  int          sent_items = 0;
  bit          in_idle_on;
  bit          out_idle_on;
  int          stall_cnt = 0;
  int          free_cnt = 0;
  int          flip_rates[5] = '{0, 5, 20, 50, 90};

  appliance_terminal_state_sensor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_len(int top);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'd0;
    if (roll == 1) return 16'd1;
    if (roll == 2) return 16'($urandom_range(top, 150));
    return 16'($urandom_range(2, top));
  endfunction

  function automatic logic [1:0] next_pins(int flip);
    for (int b = 0; b < 2; b++) begin
      if ($urandom_range(0, 99) < flip) pin_state[b] = ~pin_state[b];
    end
    return pin_state;
  endfunction

  function automatic void open_window(logic [1:0] pins);
    sensor_st.change_count = '0;
    sensor_st.previous_level = ~pins[sensor_st.active_port];
    sensor_st.run_length = '0;
    sensor_st.earlier_run_length = '0;
    sensor_st.tick_counter = '0;
  endfunction

  function automatic out_word_t step_sensor(in_word_t w);
    out_word_t   r;
    logic        lvl;
    logic        st;
    logic [16:0] sum;
    r = '0;
    unique case (sensor_st.phase)
      PH_IDLE: begin
        if (w.func == FUNC_READ || w.func == FUNC_CHANGE) begin
          if (w.port_select >= ATSS_NUM_PORTS) begin
            r.done_res = 1'b1;
            r.reported_state = REP_ERR;
          end else begin
            sensor_st.active_port = w.port_select[0];
            sensor_st.wanted_state = w.target_state;
            sensor_st.is_change = (w.func == FUNC_CHANGE);
            open_window(w.monitor_pins);
            sensor_st.phase = PH_MEAS1;
          end
        end
      end
      PH_MEAS1, PH_MEAS2: begin
        lvl = ~w.monitor_pins[sensor_st.active_port];
        if (lvl != sensor_st.previous_level) begin
          if (lvl == 1'b0 && sensor_st.change_count != 16'd0 &&
              sensor_st.run_length < sensor_cfg.glitch_ticks) begin
            sum = {1'b0, sensor_st.earlier_run_length} + {1'b0, sensor_st.run_length};
            sensor_st.change_count = sensor_st.change_count - 16'd1;
            sensor_st.run_length = sum[16] ? CNT_MAX : sum[15:0];
            sensor_st.earlier_run_length = '0;
          end else begin
            if (sensor_st.change_count != CNT_MAX)
              sensor_st.change_count = sensor_st.change_count + 16'd1;
            sensor_st.earlier_run_length = sensor_st.run_length;
            sensor_st.run_length = '0;
          end
          sensor_st.previous_level = lvl;
        end else if (sensor_st.run_length != CNT_MAX) begin
          sensor_st.run_length = sensor_st.run_length + 16'd1;
        end
        sensor_st.tick_counter = sensor_st.tick_counter + 16'd1;
        if (sensor_st.tick_counter >= sensor_cfg.window_ticks) begin
          st = (sensor_st.change_count >= 16'd2) ? 1'b1 : lvl;
          if (sensor_st.phase == PH_MEAS1 && sensor_st.is_change &&
              st != sensor_st.wanted_state) begin
            sensor_st.control_drive[sensor_st.active_port] = 1'b0;
            sensor_st.tick_counter = '0;
            sensor_st.phase = PH_PULSE;
          end else begin
            r.done_res = 1'b1;
            r.reported_state = st ? REP_ON : REP_OFF;
            r.edge_count = sensor_st.change_count;
            sensor_st.phase = PH_IDLE;
          end
        end
      end
      PH_PULSE: begin
        sensor_st.tick_counter = sensor_st.tick_counter + 16'd1;
        if (sensor_st.tick_counter >= sensor_cfg.pulse_ticks) begin
          sensor_st.control_drive = 2'b11;
          sensor_st.tick_counter = '0;
          sensor_st.phase = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (sensor_st.tick_counter >= sensor_cfg.settle_ticks) begin
          open_window(w.monitor_pins);
          sensor_st.phase = PH_MEAS2;
        end else begin
          sensor_st.tick_counter = sensor_st.tick_counter + 16'd1;
        end
      end
      default: begin
        sensor_st.phase = PH_IDLE;
        sensor_st.control_drive = 2'b11;
      end
    endcase
    r.control_pins = sensor_st.control_drive;
    r.busy_res = (sensor_st.phase != PH_IDLE);
    return r;
  endfunction

  task automatic send_word(in_word_t w);
    int        gap;
    out_word_t r;
    gap = in_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = step_sensor(w);
    pending_reports.push_back(r);
    sent_items++;
  endtask

  task automatic drive_tick(logic [1:0] f, logic [1:0] p, logic t, logic [1:0] pins);
    in_word_t w;
    w.func = f;
    w.port_select = p;
    w.target_state = t;
    w.monitor_pins = pins;
    send_word(w);
  endtask

  task automatic run_request(logic [1:0] f, logic [1:0] p, logic t, int flip);
    in_word_t w;
    w.func = f;
    w.port_select = p;
    w.target_state = t;
    w.monitor_pins = next_pins(flip);
    send_word(w);
    while (sensor_st.phase != PH_IDLE) begin
      w.func = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : FUNC_TICK;
      w.port_select = 2'($urandom_range(0, 3));
      w.target_state = 1'($urandom_range(0, 1));
      w.monitor_pins = next_pins(flip);
      send_word(w);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    unique case (idx)
      CFG_WINDOW: sensor_cfg.window_ticks = val;
      CFG_GLITCH: sensor_cfg.glitch_ticks = val;
      CFG_PULSE:  sensor_cfg.pulse_ticks = val;
      CFG_SETTLE: sensor_cfg.settle_ticks = val;
    endcase
  endtask

  task automatic load_config(logic [15:0] win, logic [15:0] glt, logic [15:0] pls,
                             logic [15:0] stl);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_GLITCH, glt);
    write_reg(CFG_PULSE, pls);
    write_reg(CFG_SETTLE, stl);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_settings();
    pin_state = 2'b10;
    run_request(FUNC_CHANGE, 2'd0, 1'b1, 0);
    wait_idle();
  endtask

  task automatic test_directed();
    load_config(16'd0, 16'd0, 16'd0, 16'd0);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b00);
    drive_tick(FUNC_SPARE, 2'd3, 1'b1, 2'b11);
    drive_tick(FUNC_READ, 2'd2, 1'b0, 2'b01);
    drive_tick(FUNC_CHANGE, 2'd3, 1'b1, 2'b10);
    drive_tick(FUNC_READ, 2'd0, 1'b0, 2'b10);
    drive_tick(FUNC_CHANGE, 2'd1, 1'b1, 2'b01);
    drive_tick(FUNC_CHANGE, 2'd1, 1'b1, 2'b11);
    drive_tick(FUNC_READ, 2'd0, 1'b0, 2'b11);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b00);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b00);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b00);
    drive_tick(FUNC_CHANGE, 2'd0, 1'b0, 2'b01);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b01);
    wait_idle();
    load_config(16'd6, 16'd3, 16'd1, 16'd0);
    drive_tick(FUNC_READ, 2'd1, 1'b0, 2'b10);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b00);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b00);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b10);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b11);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b01);
    drive_tick(FUNC_TICK, 2'd0, 1'b0, 2'b11);
    wait_idle();
  endtask

  task automatic test_longest_timing();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    load_config(16'd200, 16'd0, 16'd1, 16'd0);
    pin_state = 2'b00;
    run_request(FUNC_READ, 2'd1, 1'b0, 100);
    wait_idle();
    load_config(16'd1, 16'hffff, 16'd200, 16'd200);
    pin_state = 2'b11;
    run_request(FUNC_CHANGE, 2'd0, 1'b1, 0);
    wait_idle();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int         roll;
    int         flip;
    logic [15:0] glt;
    logic [1:0] port;
    while (sent_items < ITEM_GOAL) begin
      wait_idle();
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 9);
      glt = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hffff : 16'($urandom_range(1, 10));
      load_config(pick_len(30), glt, pick_len(20), pick_len(20));
      repeat ($urandom_range(3, 8)) begin
        if (sent_items < ITEM_GOAL) begin
          repeat ($urandom_range(0, 3)) begin
            drive_tick($urandom_range(0, 1) ? FUNC_TICK : FUNC_SPARE,
                       2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       next_pins(50));
          end
          flip = flip_rates[$urandom_range(0, 4)];
          port = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3)) :
                                               2'($urandom_range(0, 1));
          run_request($urandom_range(0, 1) ? FUNC_READ : FUNC_CHANGE, port,
                      1'($urandom_range(0, 1)), flip);
        end
      end
    end
    wait_idle();
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (!out_idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_cnt > 0) begin
      out_stall <= 1'b1;
      stall_cnt--;
    end else if (free_cnt > 0) begin
      out_stall <= 1'b0;
      free_cnt--;
    end else begin
      out_stall <= 1'b0;
      free_cnt = $urandom_range(0, 6);
      stall_cnt = pick_gap();
    end
  end

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, out_word);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("control_pins", 16'(want.control_pins), 16'(out_word.control_pins));
        check_field("busy_res", 16'(want.busy_res), 16'(out_word.busy_res));
        check_field("done_res", 16'(want.done_res), 16'(out_word.done_res));
        check_field("reported_state", 16'(want.reported_state),
                    16'(out_word.reported_state));
        check_field("edge_count", want.edge_count, out_word.edge_count);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("appliance_terminal_state_sensor_unit verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WINDOW;
    cfg_data = '0;
    pin_state = 2'b00;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    sensor_cfg.window_ticks = 16'd400;
    sensor_cfg.glitch_ticks = 16'd8;
    sensor_cfg.pulse_ticks = 16'd2200;
    sensor_cfg.settle_ticks = 16'd1300;
    sensor_st = '0;
    sensor_st.phase = PH_IDLE;
    sensor_st.control_drive = 2'b11;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_settings();
    test_directed();
    test_longest_timing();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("appliance_terminal_state_sensor_unit verification clean");
    end else begin
      $display("appliance_terminal_state_sensor_unit verification failed");
    end
    $finish;
  end

endmodule
